[src/kdl_pkg.sv]
// Package for the keyed deque list unit: codes, field widths and the
// controller/datapath command and status structs. No dependencies.
package kdl_pkg;

  localparam int KEY_W = 32;
  localparam int CMD_W = 3;
  localparam int ST_W  = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT    = 3'd0,
    CMD_DEL_KEY   = 3'd1,
    CMD_DEL_FIRST = 3'd2,
    CMD_DEL_LAST  = 3'd3,
    CMD_READ      = 3'd4
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_ENTRY    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    RD_FRONT = 2'd0,
    RD_BACK  = 2'd1,
    RD_CUR   = 2'd2,
    RD_NEXT  = 2'd3
  } rd_sel_e;

  typedef struct packed {
    logic    lat_key;
    logic    list_rd;
    rd_sel_e rd_sel;
    logic    free_rd;
    logic    alloc_hwm;
    logic    alloc_free;
    logic    do_insert;
    logic    do_unlink;
    logic    idx_clr;
    logic    idx_inc;
    logic    set_status;
    status_e status;
    logic    emit_resp;
    logic    emit_entry;
  } ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic free_avail;
    logic key_match;
    logic walk_last;
    logic out_free;
  } stat_t;

endpackage

[src/kdl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kdl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/kdl_ctrl.sv]
// Controller state machine of the keyed deque list unit.
// Depends on kdl_pkg; drives the datapath through kdl_pkg::ctrl_t.
module kdl_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [kdl_pkg::CMD_W-1:0] cmd_i,
  input  kdl_pkg::stat_t           stat_i,
  output kdl_pkg::ctrl_t           ctrl_o
);

  import kdl_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_ALLOC    = 7'b0000010,
    S_INSERT   = 7'b0000100,
    S_WALK_DEL = 7'b0001000,
    S_WALK_OUT = 7'b0010000,
    S_UNLINK   = 7'b0100000,
    S_RESP     = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  ctrl_t  ctrl;

  always_comb begin
    state_d = state_q;
    ctrl    = '0;
    ctrl.rd_sel = RD_FRONT;
    ctrl.status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl.lat_key    = 1'b1;
          ctrl.set_status = 1'b1;
          unique case (cmd_i)
            CMD_INSERT: begin
              if (stat_i.full) begin
                ctrl.status = ST_FULL;
                state_d     = S_RESP;
              end else if (stat_i.free_avail) begin
                ctrl.free_rd = 1'b1;
                state_d      = S_ALLOC;
              end else begin
                ctrl.alloc_hwm = 1'b1;
                state_d        = S_INSERT;
              end
            end
            CMD_DEL_KEY, CMD_READ: begin
              if (stat_i.empty) begin
                ctrl.status = ST_EMPTY;
                state_d     = S_RESP;
              end else begin
                ctrl.list_rd = 1'b1;
                ctrl.rd_sel  = RD_FRONT;
                ctrl.idx_clr = 1'b1;
                state_d      = (cmd_i == CMD_READ) ? S_WALK_OUT : S_WALK_DEL;
              end
            end
            CMD_DEL_FIRST, CMD_DEL_LAST: begin
              if (stat_i.empty) begin
                ctrl.status = ST_EMPTY;
                state_d     = S_RESP;
              end else begin
                ctrl.list_rd = 1'b1;
                ctrl.rd_sel  = (cmd_i == CMD_DEL_LAST) ? RD_BACK : RD_FRONT;
                state_d      = S_UNLINK;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_ALLOC: begin
        ctrl.alloc_free = 1'b1;
        state_d         = S_INSERT;
      end
      S_INSERT: begin
        ctrl.do_insert  = 1'b1;
        ctrl.set_status = 1'b1;
        state_d         = S_RESP;
      end
      S_WALK_DEL: begin
        if (stat_i.key_match) begin
          ctrl.list_rd = 1'b1;
          ctrl.rd_sel  = RD_CUR;
          state_d      = S_UNLINK;
        end else if (stat_i.walk_last) begin
          ctrl.set_status = 1'b1;
          ctrl.status     = ST_NOTFOUND;
          state_d         = S_RESP;
        end else begin
          ctrl.list_rd = 1'b1;
          ctrl.rd_sel  = RD_NEXT;
          ctrl.idx_inc = 1'b1;
        end
      end
      S_WALK_OUT: begin
        if (stat_i.out_free) begin
          ctrl.emit_entry = 1'b1;
          if (stat_i.walk_last) begin
            state_d = S_IDLE;
          end else begin
            ctrl.list_rd = 1'b1;
            ctrl.rd_sel  = RD_NEXT;
            ctrl.idx_inc = 1'b1;
          end
        end
      end
      S_UNLINK: begin
        ctrl.do_unlink  = 1'b1;
        ctrl.set_status = 1'b1;
        state_d         = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          ctrl.emit_resp = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign ctrl_o     = ctrl;

endmodule

[src/kdl_dp.sv]
// Datapath of the keyed deque list unit: key, link and free-slot memories,
// list pointers, counters and the output register. Depends on kdl_pkg, kdl_ram.
module kdl_dp #(
  parameter int CAPACITY = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  kdl_pkg::ctrl_t                  ctrl_i,
  output kdl_pkg::stat_t                  stat_o,
  input  logic signed [kdl_pkg::KEY_W-1:0] key_in_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [kdl_pkg::KEY_W-1:0] key_out_o,
  output logic [kdl_pkg::ST_W-1:0]        status_o,
  output logic                            last_o
);

  import kdl_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [AW-1:0] front_q, front_d, back_q, back_d, cur_q, cur_d;
  logic [CW-1:0] count_q, count_d, hwm_q, hwm_d, fcnt_q, fcnt_d, idx_q, idx_d;
  logic [CW-1:0] fpop;
  logic [KEY_W-1:0] key_q;
  status_e          status_q;

  logic                     out_valid_q, out_valid_d;
  logic [KEY_W-1:0]         out_key_q;
  logic [ST_W-1:0]          out_status_q;
  logic                     out_last_q;

  logic [AW-1:0]    rd_addr;
  logic [KEY_W-1:0] key_rdata;
  logic [AW-1:0]    next_rdata, prev_rdata, free_rdata;

  logic          is_front, is_back, middle, empty, out_free, walk_last;
  logic          next_we, prev_we;
  logic [AW-1:0] next_waddr, next_wdata, prev_waddr, prev_wdata;

  assign empty     = (count_q == '0);
  assign walk_last = ((idx_q + CW'(1)) == count_q);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign fpop      = fcnt_q - CW'(1);

  assign is_front = (cur_q == front_q);
  assign is_back  = (cur_q == back_q);
  assign middle   = !is_front && !is_back;

  always_comb begin
    unique case (ctrl_i.rd_sel)
      RD_FRONT: rd_addr = front_q;
      RD_BACK:  rd_addr = back_q;
      RD_CUR:   rd_addr = cur_q;
      RD_NEXT:  rd_addr = next_rdata;
      default:  rd_addr = front_q;
    endcase
  end

  assign next_we    = ctrl_i.do_insert || (ctrl_i.do_unlink && middle);
  assign next_waddr = ctrl_i.do_insert ? cur_q : prev_rdata;
  assign next_wdata = ctrl_i.do_insert ? front_q : next_rdata;
  assign prev_we    = (ctrl_i.do_insert && !empty) || (ctrl_i.do_unlink && middle);
  assign prev_waddr = ctrl_i.do_insert ? front_q : next_rdata;
  assign prev_wdata = ctrl_i.do_insert ? cur_q : prev_rdata;

  kdl_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.do_insert),
    .waddr_i (cur_q),
    .wdata_i (key_q),
    .re_i    (ctrl_i.list_rd),
    .raddr_i (rd_addr),
    .rdata_o (key_rdata)
  );

  kdl_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .re_i    (ctrl_i.list_rd),
    .raddr_i (rd_addr),
    .rdata_o (next_rdata)
  );

  kdl_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .re_i    (ctrl_i.list_rd),
    .raddr_i (rd_addr),
    .rdata_o (prev_rdata)
  );

  kdl_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.do_unlink),
    .waddr_i (fcnt_q[AW-1:0]),
    .wdata_i (cur_q),
    .re_i    (ctrl_i.free_rd),
    .raddr_i (fpop[AW-1:0]),
    .rdata_o (free_rdata)
  );

  always_comb begin
    front_d = front_q;
    back_d  = back_q;
    count_d = count_q;
    hwm_d   = hwm_q;
    fcnt_d  = fcnt_q;
    idx_d   = idx_q;
    cur_d   = cur_q;
    if (ctrl_i.list_rd) begin
      cur_d = rd_addr;
    end else if (ctrl_i.alloc_hwm) begin
      cur_d = hwm_q[AW-1:0];
      hwm_d = hwm_q + CW'(1);
    end else if (ctrl_i.alloc_free) begin
      cur_d  = free_rdata;
      fcnt_d = fpop;
    end
    if (ctrl_i.idx_clr) begin
      idx_d = '0;
    end else if (ctrl_i.idx_inc) begin
      idx_d = idx_q + CW'(1);
    end
    if (ctrl_i.do_insert) begin
      front_d = cur_q;
      if (empty) begin
        back_d = cur_q;
      end
      count_d = count_q + CW'(1);
    end
    if (ctrl_i.do_unlink) begin
      if (is_front && !is_back) begin
        front_d = next_rdata;
      end
      if (is_back && !is_front) begin
        back_d = prev_rdata;
      end
      count_d = count_q - CW'(1);
      fcnt_d  = fcnt_q + CW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_i.emit_resp || ctrl_i.emit_entry) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      back_q      <= '0;
      count_q     <= '0;
      hwm_q       <= '0;
      fcnt_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      front_q     <= front_d;
      back_q      <= back_d;
      count_q     <= count_d;
      hwm_q       <= hwm_d;
      fcnt_q      <= fcnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (ctrl_i.lat_key) begin
      key_q <= key_in_i;
    end
    if (ctrl_i.set_status) begin
      status_q <= ctrl_i.status;
    end
    if (ctrl_i.emit_resp) begin
      out_key_q    <= '0;
      out_status_q <= status_q;
      out_last_q   <= 1'b1;
    end else if (ctrl_i.emit_entry) begin
      out_key_q    <= key_rdata;
      out_status_q <= ST_ENTRY;
      out_last_q   <= walk_last;
    end
  end

  assign stat_o.empty      = empty;
  assign stat_o.full       = (count_q == CW'(CAPACITY));
  assign stat_o.free_avail = (fcnt_q != '0);
  assign stat_o.key_match  = (key_rdata == key_q);
  assign stat_o.walk_last  = walk_last;
  assign stat_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign key_out_o   = out_key_q;
  assign status_o    = out_status_q;
  assign last_o      = out_last_q;

endmodule

[src/keyed_deque_list_unit.sv]
// Keyed deque list unit, top level: joins the controller and the datapath.
// Depends on kdl_pkg, kdl_ctrl, kdl_dp (and kdl_ram through kdl_dp).
//
// Bounded doubly linked list of up to CAPACITY signed 32-bit keys kept in
// key, link and free-slot RAMs with registered reads. One request at a time:
// a new request is taken only when the previous one has handed its last
// result to the output register. Insert passes S_ALLOC (only when it reuses
// a freed slot) and S_INSERT, delete first/last passes S_UNLINK, and each
// then waits in S_RESP. Delete by key and read-out walk the list, one link
// per cycle (read-out only while the output is not stalled), through the
// registered read of the key and next-link RAMs; delete by key then unlinks.
// No clearing pass after reset: slots are handed out by a fill count and a
// free-slot stack. Results carry last on the final one of each request.
module keyed_deque_list_unit #(
  parameter int CAPACITY = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [kdl_pkg::CMD_W-1:0]        cmd_i,
  input  logic signed [kdl_pkg::KEY_W-1:0] key_in_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [kdl_pkg::KEY_W-1:0] key_out_o,
  output logic [kdl_pkg::ST_W-1:0]         status_o,
  output logic                             last_o
);

  import kdl_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  kdl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  kdl_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .key_in_i    (key_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .key_out_o   (key_out_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule
